// ----- rtl/core/lrr_pkg.sv -----
// Shared types and constants for the line and rectangle rasterizer.
`default_nettype none

package lrr_pkg;

  localparam int COORD_BITS = 8;
  localparam int COLOR_BITS = 16;
  localparam int ERR_BITS   = COORD_BITS + 2;

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic [COLOR_BITS-1:0]      color_t;
  typedef logic signed [ERR_BITS-1:0] err_t;
  typedef logic [1:0]                 edge_idx_t;

  // Request codes carried on the func field.
  typedef enum logic [1:0] {
    FN_LINE = 2'd0,
    FN_RECT = 2'd1,
    FN_STEP = 2'd2
  } func_t;

  localparam edge_idx_t LAST_EDGE = 2'd3;

  // Corner slots of the stored rectangle.
  localparam int CRN_R0 = 0;
  localparam int CRN_C0 = 1;
  localparam int CRN_R1 = 2;
  localparam int CRN_C1 = 3;

  typedef struct packed {
    logic [1:0] func;
    coord_t     row0;
    coord_t     col0;
    coord_t     row1;
    coord_t     col1;
    color_t     pen_color;
  } req_t;

  typedef struct packed {
    coord_t cur_row;
    coord_t cur_col;
    coord_t end_row;
    coord_t end_col;
    logic   row_dir_neg;
    logic   col_dir_neg;
    coord_t span_row;
    coord_t span_col;
    err_t   err_acc;
  } line_t;

  typedef struct packed {
    line_t               line;
    color_t              held_color;
    logic                busy;
    logic                rect_mode;
    edge_idx_t           edge_index;
    logic [3:0][COORD_BITS-1:0] rect_corners;
  } st_t;

  typedef struct packed {
    logic   valid_res;
    coord_t pixel_row;
    coord_t pixel_col;
    color_t pixel_color;
    logic   last;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/lrr_step.sv -----
// Combinational next-state and pixel logic for one rasterizer request.
`default_nettype none

module lrr_step (
  input  wire lrr_pkg::req_t req,
  input  wire lrr_pkg::st_t  cur,
  output lrr_pkg::st_t  nxt,
  output lrr_pkg::res_t res
);

  typedef struct packed {
    logic           ok;
    lrr_pkg::coord_t row;
    lrr_pkg::coord_t col;
    lrr_pkg::err_t   err;
  } adv_t;

  function automatic lrr_pkg::line_t load_line(lrr_pkg::coord_t r0, lrr_pkg::coord_t c0,
                                               lrr_pkg::coord_t r1, lrr_pkg::coord_t c1);
    lrr_pkg::line_t l;
    l.cur_row     = r0;
    l.cur_col     = c0;
    l.end_row     = r1;
    l.end_col     = c1;
    l.span_row    = (r0 > r1) ? r0 - r1 : r1 - r0;
    l.span_col    = (c0 > c1) ? c0 - c1 : c1 - c0;
    l.row_dir_neg = !(r0 < r1);
    l.col_dir_neg = !(c0 < c1);
    l.err_acc     = $signed({2'b00, l.span_row}) - $signed({2'b00, l.span_col});
    return l;
  endfunction

  // Edges in tracing order: left upward, top leftward, right downward, bottom rightward.
  function automatic lrr_pkg::line_t load_edge(logic [3:0][lrr_pkg::COORD_BITS-1:0] crn,
                                               lrr_pkg::edge_idx_t k);
    lrr_pkg::line_t l;
    case (k)
      2'd0:    l = load_line(crn[lrr_pkg::CRN_R1], crn[lrr_pkg::CRN_C0],
                             crn[lrr_pkg::CRN_R0], crn[lrr_pkg::CRN_C0]);
      2'd1:    l = load_line(crn[lrr_pkg::CRN_R0], crn[lrr_pkg::CRN_C1],
                             crn[lrr_pkg::CRN_R0], crn[lrr_pkg::CRN_C0]);
      2'd2:    l = load_line(crn[lrr_pkg::CRN_R0], crn[lrr_pkg::CRN_C1],
                             crn[lrr_pkg::CRN_R1], crn[lrr_pkg::CRN_C1]);
      default: l = load_line(crn[lrr_pkg::CRN_R1], crn[lrr_pkg::CRN_C0],
                             crn[lrr_pkg::CRN_R1], crn[lrr_pkg::CRN_C1]);
    endcase
    return l;
  endfunction

  // One Bresenham move; ok is low when the line ends instead.
  function automatic adv_t advance(lrr_pkg::line_t l);
    adv_t a;
    logic signed [lrr_pkg::ERR_BITS:0] e2;
    logic signed [lrr_pkg::ERR_BITS:0] dx;
    logic signed [lrr_pkg::ERR_BITS:0] dy;
    e2    = $signed({l.err_acc, 1'b0});
    dx    = $signed({3'b000, l.span_row});
    dy    = -$signed({3'b000, l.span_col});
    a.ok  = 1'b1;
    a.row = l.cur_row;
    a.col = l.cur_col;
    a.err = l.err_acc;
    if (l.cur_row == l.end_row && l.cur_col == l.end_col) begin
      a.ok = 1'b0;
    end else begin
      if (e2 >= dy) begin
        if (l.cur_row == l.end_row) begin
          a.ok = 1'b0;
        end else begin
          a.err = a.err - $signed({2'b00, l.span_col});
          a.row = l.row_dir_neg ? a.row - lrr_pkg::coord_t'(1) : a.row + lrr_pkg::coord_t'(1);
        end
      end
      if (a.ok && e2 <= dx) begin
        if (l.cur_col == l.end_col) begin
          a.ok = 1'b0;
        end else begin
          a.err = a.err + $signed({2'b00, l.span_row});
          a.col = l.col_dir_neg ? a.col - lrr_pkg::coord_t'(1) : a.col + lrr_pkg::coord_t'(1);
        end
      end
    end
    return a;
  endfunction

  adv_t step_adv;
  adv_t look_adv;
  logic do_emit;
  logic fin;

  always_comb begin
    nxt      = cur;
    do_emit  = 1'b0;
    step_adv = '0;
    case (lrr_pkg::func_t'(req.func))
      lrr_pkg::FN_LINE: begin
        nxt.held_color = req.pen_color;
        nxt.rect_mode  = 1'b0;
        nxt.edge_index = '0;
        nxt.busy       = 1'b1;
        nxt.line       = load_line(req.row0, req.col0, req.row1, req.col1);
        do_emit        = 1'b1;
      end
      lrr_pkg::FN_RECT: begin
        nxt.held_color                    = req.pen_color;
        nxt.rect_mode                     = 1'b1;
        nxt.edge_index                    = '0;
        nxt.busy                          = 1'b1;
        nxt.rect_corners[lrr_pkg::CRN_R0] = req.row0;
        nxt.rect_corners[lrr_pkg::CRN_C0] = req.col0;
        nxt.rect_corners[lrr_pkg::CRN_R1] = req.row1;
        nxt.rect_corners[lrr_pkg::CRN_C1] = req.col1;
        nxt.line    = load_edge(nxt.rect_corners, '0);
        do_emit     = 1'b1;
      end
      lrr_pkg::FN_STEP: begin
        if (cur.busy) begin
          step_adv = advance(cur.line);
          if (step_adv.ok) begin
            nxt.line.cur_row = step_adv.row;
            nxt.line.cur_col = step_adv.col;
            nxt.line.err_acc = step_adv.err;
          end else begin
            nxt.edge_index = cur.edge_index + lrr_pkg::edge_idx_t'(1);
            nxt.line       = load_edge(cur.rect_corners, nxt.edge_index);
          end
          do_emit = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Look one move ahead to flag the final pixel of the shape.
    look_adv = advance(nxt.line);
    fin = do_emit && !look_adv.ok &&
          !(nxt.rect_mode && nxt.edge_index != lrr_pkg::LAST_EDGE);
    if (fin) begin
      nxt.busy = 1'b0;
    end

    res = '0;
    if (do_emit) begin
      res.valid_res   = 1'b1;
      res.pixel_row   = nxt.line.cur_row;
      res.pixel_col   = nxt.line.cur_col;
      res.pixel_color = nxt.held_color;
      res.last        = fin;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/line_and_rectangle_rasterizer.sv -----
// Top level of the line and rectangle outline pixel generator.
// Structure: one request register and one result register around lrr_step; the result
// of an accepted request is registered in the result register, which drives out_.
// Throughput: one request per cycle while out_ready holds; while a result waits on out_,
// a request is taken only into an empty request register.
// Reset (rst_n low, synchronous) empties both registers and leaves the generator idle.
`default_nettype none

module line_and_rectangle_rasterizer (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic [1:0]                 in_func,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] in_row0,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] in_col0,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] in_row1,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] in_col1,
  input  wire logic [lrr_pkg::COLOR_BITS-1:0] in_pen_color,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic                       out_valid_res,
  output      logic [lrr_pkg::COORD_BITS-1:0] out_pixel_row,
  output      logic [lrr_pkg::COORD_BITS-1:0] out_pixel_col,
  output      logic [lrr_pkg::COLOR_BITS-1:0] out_pixel_color,
  output      logic                       out_last
);

  // The request register decouples the input side from a stalled output.
  // The shape state is updated at the same edge a request moves into the
  // result register, so the next request always sees the state its
  // predecessor left behind.
  logic          req_valid_r;
  lrr_pkg::req_t req_r;
  lrr_pkg::st_t  state_r;
  lrr_pkg::st_t  state_nxt;
  lrr_pkg::res_t res_nxt;
  logic          out_valid_r;
  lrr_pkg::res_t res_r;
  logic          fire;

  // A request is processed whenever the result register is empty or drains.
  assign fire     = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || fire;

  lrr_step u_step (
    .req (req_r),
    .cur (state_r),
    .nxt (state_nxt),
    .res (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_ready) begin
        req_valid_r <= in_valid;
      end
      if (fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.func      <= in_func;
      req_r.row0      <= in_row0;
      req_r.col0      <= in_col0;
      req_r.row1      <= in_row1;
      req_r.col1      <= in_col1;
      req_r.pen_color <= in_pen_color;
    end
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_valid_res   = res_r.valid_res;
  assign out_pixel_row   = res_r.pixel_row;
  assign out_pixel_col   = res_r.pixel_col;
  assign out_pixel_color = res_r.pixel_color;
  assign out_last        = res_r.last;

  // The generator only goes idle on the request that produced the last pixel.
  a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r.busy) && !state_r.busy) |-> (out_valid_r && res_r.last))
    else $error("generator went idle without a last pixel");

  // A last flag always comes with a pixel.
  a_last_has_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.last) |-> res_r.valid_res)
    else $error("last flag on a result without a pixel");

  // Every start request yields a pixel and leaves a shape in progress or finished.
  a_start_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (req_r.func == lrr_pkg::FN_LINE || req_r.func == lrr_pkg::FN_RECT))
      |=> (out_valid_r && res_r.valid_res && (state_r.busy || res_r.last)))
    else $error("start request did not emit a pixel");

endmodule

`default_nettype wire

// ----- tb/lrr_pixel_checker.sv -----
// Checker for the rasterizer: predicts each pixel result and compares it against the out_ channel.
`timescale 1ns / 100ps

module lrr_pixel_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire logic [1:0]                     in_func,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] in_row0,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] in_col0,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] in_row1,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] in_col1,
  input  wire logic [lrr_pkg::COLOR_BITS-1:0] in_pen_color,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire logic                           out_valid_res,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] out_pixel_row,
  input  wire logic [lrr_pkg::COORD_BITS-1:0] out_pixel_col,
  input  wire logic [lrr_pkg::COLOR_BITS-1:0] out_pixel_color,
  input  wire logic                           out_last,
  output int                                  fail_count,
  output int                                  pending
);

  // Private copy of the generator state.
  lrr_pkg::coord_t    cur_row, cur_col, end_row, end_col, span_row, span_col;
  logic               row_neg, col_neg, busy, rect_on;
  lrr_pkg::err_t      err;
  lrr_pkg::color_t    pen;
  lrr_pkg::edge_idx_t edge_no;
  lrr_pkg::coord_t    corner [4];

  lrr_pkg::res_t expected_px [$];
  int            mismatches = 0;

  function automatic void clear_state();
    cur_row  = '0;
    cur_col  = '0;
    end_row  = '0;
    end_col  = '0;
    span_row = '0;
    span_col = '0;
    row_neg  = 1'b0;
    col_neg  = 1'b0;
    busy     = 1'b0;
    rect_on  = 1'b0;
    err      = '0;
    pen      = '0;
    edge_no  = '0;
    for (int i = 0; i < 4; i++) corner[i] = '0;
  endfunction

  function automatic void load_seg(lrr_pkg::coord_t r0, lrr_pkg::coord_t c0,
                                   lrr_pkg::coord_t r1, lrr_pkg::coord_t c1);
    cur_row  = r0;
    cur_col  = c0;
    end_row  = r1;
    end_col  = c1;
    span_row = (r0 > r1) ? r0 - r1 : r1 - r0;
    span_col = (c0 > c1) ? c0 - c1 : c1 - c0;
    row_neg  = !(r0 < r1);
    col_neg  = !(c0 < c1);
    err      = lrr_pkg::err_t'(int'(span_row) - int'(span_col));
  endfunction

  // Edges of the outline, traced in a fixed order.
  function automatic void load_side(lrr_pkg::edge_idx_t k);
    case (k)
      2'd0:    load_seg(corner[lrr_pkg::CRN_R1], corner[lrr_pkg::CRN_C0],
                        corner[lrr_pkg::CRN_R0], corner[lrr_pkg::CRN_C0]);
      2'd1:    load_seg(corner[lrr_pkg::CRN_R0], corner[lrr_pkg::CRN_C1],
                        corner[lrr_pkg::CRN_R0], corner[lrr_pkg::CRN_C0]);
      2'd2:    load_seg(corner[lrr_pkg::CRN_R0], corner[lrr_pkg::CRN_C1],
                        corner[lrr_pkg::CRN_R1], corner[lrr_pkg::CRN_C1]);
      default: load_seg(corner[lrr_pkg::CRN_R1], corner[lrr_pkg::CRN_C0],
                        corner[lrr_pkg::CRN_R1], corner[lrr_pkg::CRN_C1]);
    endcase
  endfunction

  // One Bresenham move; returns 0 when the segment ends instead of moving.
  function automatic bit step_ok(inout lrr_pkg::coord_t r, inout lrr_pkg::coord_t c,
                                 inout lrr_pkg::err_t e);
    int e2;
    if (r == end_row && c == end_col) return 1'b0;
    e2 = 2 * int'(e);
    if (e2 >= -int'(span_col)) begin
      if (r == end_row) return 1'b0;
      e = lrr_pkg::err_t'(int'(e) - int'(span_col));
      r = row_neg ? r - 1'b1 : r + 1'b1;
    end
    if (e2 <= int'(span_row)) begin
      if (c == end_col) return 1'b0;
      e = lrr_pkg::err_t'(int'(e) + int'(span_row));
      c = col_neg ? c - 1'b1 : c + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic lrr_pkg::res_t emit_px();
    lrr_pkg::res_t   px;
    lrr_pkg::coord_t r, c;
    lrr_pkg::err_t   e;
    bit              fin;
    r   = cur_row;
    c   = cur_col;
    e   = err;
    fin = !step_ok(r, c, e) && !(rect_on && edge_no < lrr_pkg::LAST_EDGE);
    px.valid_res   = 1'b1;
    px.pixel_row   = cur_row;
    px.pixel_col   = cur_col;
    px.pixel_color = pen;
    px.last        = fin;
    if (fin) busy = 1'b0;
    return px;
  endfunction

  function automatic lrr_pkg::res_t predict_px(logic [1:0] fn, lrr_pkg::coord_t r0,
                                               lrr_pkg::coord_t c0, lrr_pkg::coord_t r1,
                                               lrr_pkg::coord_t c1, lrr_pkg::color_t pc);
    lrr_pkg::res_t px;
    px = '0;
    if (fn == lrr_pkg::FN_LINE) begin
      pen     = pc;
      rect_on = 1'b0;
      edge_no = '0;
      busy    = 1'b1;
      load_seg(r0, c0, r1, c1);
      px = emit_px();
    end else if (fn == lrr_pkg::FN_RECT) begin
      pen     = pc;
      rect_on = 1'b1;
      edge_no = '0;
      busy    = 1'b1;
      corner[lrr_pkg::CRN_R0] = r0;
      corner[lrr_pkg::CRN_C0] = c0;
      corner[lrr_pkg::CRN_R1] = r1;
      corner[lrr_pkg::CRN_C1] = c1;
      load_side(edge_no);
      px = emit_px();
    end else if (fn == lrr_pkg::FN_STEP && busy) begin
      if (!step_ok(cur_row, cur_col, err)) begin
        edge_no = edge_no + 1'b1;
        load_side(edge_no);
      end
      px = emit_px();
    end
    return px;
  endfunction

  always @(posedge clk) begin : watch
    lrr_pkg::res_t got, want;
    if (!rst_n) begin
      clear_state();
      expected_px.delete();
    end else begin
      // Results are retired before new requests are predicted: a result leaving at this
      // edge can never belong to a request entering at the same edge.
      if (out_valid && out_ready) begin
        got.valid_res   = out_valid_res;
        got.pixel_row   = out_pixel_row;
        got.pixel_col   = out_pixel_col;
        got.pixel_color = out_pixel_color;
        got.last        = out_last;
        if (expected_px.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result v=%0d r=%0d c=%0d col=%h l=%0d",
                     $time, got.valid_res, got.pixel_row, got.pixel_col, got.pixel_color,
                     got.last);
        end else begin
          want = expected_px.pop_front();
          if (got.valid_res !== want.valid_res || got.pixel_row !== want.pixel_row ||
              got.pixel_col !== want.pixel_col || got.pixel_color !== want.pixel_color ||
              got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: pixel mismatch exp v=%0d r=%0d c=%0d col=%h l=%0d",
                       $time, want.valid_res, want.pixel_row, want.pixel_col,
                       want.pixel_color, want.last);
              $display("    got v=%0d r=%0d c=%0d col=%h l=%0d",
                       got.valid_res, got.pixel_row, got.pixel_col, got.pixel_color,
                       got.last);
            end
          end
        end
      end
      if (in_valid && in_ready)
        expected_px.push_back(predict_px(in_func, in_row0, in_col0, in_row1, in_col1,
                                         in_pen_color));
    end
    fail_count <= mismatches;
    pending    <= expected_px.size();
  end

endmodule

// ----- tb/line_and_rectangle_rasterizer_tb.sv -----
// Top of the rasterizer testbench: clock, reset, request stimulus, result stalls and verdict.
`timescale 1ns / 100ps

module line_and_rectangle_rasterizer_tb;

  // The fourth func code has no meaning; the block must answer it with an empty result.
  localparam logic [1:0] FN_UNUSED = 2'd3;

  // Length of the long receiver hold-off used to back the block up into its input.
  localparam int HOLD_CYCLES = 300;

  // Random requests per idling phase; four phases give roughly two thousand.
  localparam int PHASE_ITEMS = 480;

  logic   clk   = 1'b0;
  logic   rst_n = 1'b0;

  logic            in_valid     = 1'b0;
  logic            in_ready;
  logic [1:0]      in_func      = lrr_pkg::FN_STEP;
  lrr_pkg::coord_t in_row0      = '0;
  lrr_pkg::coord_t in_col0      = '0;
  lrr_pkg::coord_t in_row1      = '0;
  lrr_pkg::coord_t in_col1      = '0;
  lrr_pkg::color_t in_pen_color = '0;

  logic            out_valid;
  logic            out_ready    = 1'b0;
  logic            out_valid_res;
  lrr_pkg::coord_t out_pixel_row;
  lrr_pkg::coord_t out_pixel_col;
  lrr_pkg::color_t out_pixel_color;
  logic            out_last;

  int fail_count;
  int pending;

  // Idling controls. The sender's percentage is only read by the stimulus process;
  // the receiver's is written with nonblocking assignments since another process reads it.
  int send_idle_pct = 0;
  int stall_pct     = 0;

  // The stimulus process flips hold_tgl to ask the receiver for a long hold-off.
  logic hold_tgl  = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  // Requests that belong to line or rectangle traffic (ignored codes are not counted).
  int shaped_items = 0;

  always #6 clk = ~clk;

  line_and_rectangle_rasterizer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_row0         (in_row0),
    .in_col0         (in_col0),
    .in_row1         (in_row1),
    .in_col1         (in_col1),
    .in_pen_color    (in_pen_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_valid_res   (out_valid_res),
    .out_pixel_row   (out_pixel_row),
    .out_pixel_col   (out_pixel_col),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last)
  );

  lrr_pixel_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_row0         (in_row0),
    .in_col0         (in_col0),
    .in_row1         (in_row1),
    .in_col1         (in_col1),
    .in_pen_color    (in_pen_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_valid_res   (out_valid_res),
    .out_pixel_row   (out_pixel_row),
    .out_pixel_col   (out_pixel_col),
    .out_pixel_color (out_pixel_color),
    .out_last        (out_last),
    .fail_count      (fail_count),
    .pending         (pending)
  );

  // Result side. Ready is decided once per edge: either the long hold-off is running,
  // or a random stall at the current phase's rate.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_tgl != hold_seen) begin
        hold_seen = hold_tgl;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  function automatic lrr_pkg::coord_t rnd_coord();
    return lrr_pkg::coord_t'($urandom);
  endfunction

  function automatic lrr_pkg::color_t rnd_color();
    return lrr_pkg::color_t'($urandom);
  endfunction

  // Offer one request and hold it until the block takes it. Idle cycles before the
  // request keep valid low; back-to-back requests keep valid high without a dip.
  task automatic send_req(input logic [1:0] fn, input lrr_pkg::coord_t r0,
                          input lrr_pkg::coord_t c0, input lrr_pkg::coord_t r1,
                          input lrr_pkg::coord_t c1, input lrr_pkg::color_t pc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_func      <= fn;
    in_row0      <= r0;
    in_col0      <= c0;
    in_row1      <= r1;
    in_col1      <= c1;
    in_pen_color <= pc;
    do @(posedge clk); while (!in_ready);
  endtask

  // A step request carries fields the block ignores; they are randomized anyway.
  task automatic send_step();
    send_req(lrr_pkg::FN_STEP, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
             rnd_color());
  endtask

  // Start a line or rectangle and follow it with a number of step requests. Too few
  // steps leave the shape to be abandoned by the next start; too many produce steps
  // while idle. Now and then an undefined code is slipped in while the shape is busy.
  task automatic run_shape(input logic [1:0] fn, input lrr_pkg::coord_t r0,
                           input lrr_pkg::coord_t c0, input lrr_pkg::coord_t r1,
                           input lrr_pkg::coord_t c1, input lrr_pkg::color_t pc,
                           input int steps);
    send_req(fn, r0, c0, r1, c1, pc);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 99) < 3)
        send_req(FN_UNUSED, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                 rnd_color());
      send_step();
    end
    shaped_items += 1 + steps;
  endtask

  // Mostly short shapes at random places, an occasional one with end points anywhere in the frame.
  task automatic random_shape();
    bit              is_rect, big;
    int              len_r, len_c, dr, dc, est, steps;
    lrr_pkg::coord_t r0, c0, r1, c1;
    is_rect = ($urandom_range(0, 1) == 1);
    big     = ($urandom_range(0, 39) == 0);
    if (big) begin
      r0 = rnd_coord();
      c0 = rnd_coord();
      r1 = rnd_coord();
      c1 = rnd_coord();
    end else begin
      len_r = $urandom_range(0, 6);
      len_c = $urandom_range(0, 6);
      r0 = lrr_pkg::coord_t'($urandom_range(0, 255 - len_r));
      c0 = lrr_pkg::coord_t'($urandom_range(0, 255 - len_c));
      r1 = lrr_pkg::coord_t'(int'(r0) + len_r);
      c1 = lrr_pkg::coord_t'(int'(c0) + len_c);
      if ($urandom_range(0, 1) == 1) {r0, r1} = {r1, r0};
      if ($urandom_range(0, 1) == 1) {c0, c1} = {c1, c0};
    end
    dr  = (r0 > r1) ? int'(r0) - int'(r1) : int'(r1) - int'(r0);
    dc  = (c0 > c1) ? int'(c0) - int'(c1) : int'(c1) - int'(c0);
    // Steps needed after the start pixel if every segment runs to its end point.
    est = is_rect ? 2 * dr + 2 * dc + 3 : ((dr > dc) ? dr : dc);
    if ($urandom_range(0, 99) < 12)
      steps = $urandom_range(0, est);
    else
      steps = est + $urandom_range(0, 2);
    run_shape(is_rect ? lrr_pkg::FN_RECT : lrr_pkg::FN_LINE, r0, c0, r1, c1, rnd_color(),
              steps);
  endtask

  // Stop offering requests and wait until every predicted result has come back.
  // The first edge lets the checker's count catch up with the last accepted request.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_v);
    int first;
    send_idle_pct = idle_pct;
    stall_pct    <= stall_v;
    first         = shaped_items;
    while (shaped_items - first < PHASE_ITEMS) begin
      if ($urandom_range(0, 99) < 5)
        send_req(($urandom_range(0, 1) == 1) ? lrr_pkg::FN_STEP : FN_UNUSED,
                 rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), rnd_color());
      else
        random_shape();
    end
    drain();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening. Right after reset nothing is busy, so a step and the undefined
    // code must both come back as empty results.
    send_req(lrr_pkg::FN_STEP, 8'd255, 8'd255, 8'd255, 8'd255, 16'hFFFF);
    send_req(FN_UNUSED, '0, '0, '0, '0, '0);
    // A line whose end points coincide is finished on its first pixel.
    run_shape(lrr_pkg::FN_LINE, 8'd0, 8'd0, 8'd0, 8'd0, 16'h0000, 0);
    // Corner to corner across the frame, abandoned at once by the next start.
    run_shape(lrr_pkg::FN_LINE, 8'd255, 8'd0, 8'd0, 8'd255, 16'hFFFF, 0);
    // A short line with an undefined code while busy, then one step too many.
    send_req(lrr_pkg::FN_LINE, 8'd0, 8'd0, 8'd3, 8'd1, 16'hA5A5);
    send_req(FN_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    repeat (4) send_step();
    // A line cut short by a rectangle start, which is then traced to its last corner.
    run_shape(lrr_pkg::FN_LINE, 8'd10, 8'd25, 8'd20, 8'd10, 16'h1234, 2);
    run_shape(lrr_pkg::FN_RECT, 8'd6, 8'd6, 8'd5, 8'd5, 16'h5A5A, 7);
    // A rectangle collapsed to a single point still traces four one-pixel edges.
    run_shape(lrr_pkg::FN_RECT, 8'd128, 8'd128, 8'd128, 8'd128, 16'h8001, 3);
    drain();

    // No idling. The receiver first holds off long enough for the block to fill up
    // and stall its input while requests keep coming.
    hold_tgl <= ~hold_tgl;
    run_phase(0, 0);
    run_phase(72, 0);
    run_phase(0, 72);
    run_phase(27, 27);

    // Everything is back; keep the clock running so that any stray result would show.
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
